[rtl/wbts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbts_pkg
// Shared types, codes and helpers for the water batch treatment sequencer.
// ----------------------------------------------------------------------------
package wbts_pkg;

  // Phase codes, as shown on the result channel.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_FILTER  = 3'd1;
  localparam logic [2:0] PH_SETTLE  = 3'd2;
  localparam logic [2:0] PH_TEST    = 3'd3;
  localparam logic [2:0] PH_RECIRC  = 3'd4;
  localparam logic [2:0] PH_DELIVER = 3'd5;
  localparam logic [2:0] PH_REJECT  = 3'd6;
  localparam logic [2:0] PH_DRY     = 3'd7;

  // Rejection reasons.
  localparam logic [2:0] RSN_NONE      = 3'd0;
  localparam logic [2:0] RSN_PH        = 3'd1;
  localparam logic [2:0] RSN_SENSOR    = 3'd2;
  localparam logic [2:0] RSN_MAX_PASS  = 3'd3;
  localparam logic [2:0] RSN_NO_IMPROV = 3'd4;

  // Verdict codes on the input stream.
  localparam logic [1:0] VERDICT_OK     = 2'd0;
  localparam logic [1:0] VERDICT_PH     = 2'd1;
  localparam logic [1:0] VERDICT_SENSOR = 2'd2;
  localparam logic [1:0] VERDICT_TURBID = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_RAW_MIN_LEVEL   = 3'd0;
  localparam logic [2:0] REG_PASS_DURATION   = 3'd1;
  localparam logic [2:0] REG_SETTLE          = 3'd2;
  localparam logic [2:0] REG_MAX_PASSES      = 3'd3;
  localparam logic [2:0] REG_MIN_IMPROVEMENT = 3'd4;

  // Bit positions inside the drive word.
  localparam int DRV_PUMP   = 0;
  localparam int DRV_CLEAN  = 1;
  localparam int DRV_RECIRC = 2;
  localparam int DRV_WASTE  = 3;

  // Stream data widths (fields packed from bit 0, padded to whole bytes).
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;

  // Register reset values.
  localparam logic [11:0] RST_RAW_MIN_LEVEL   = 12'd100;
  localparam logic [31:0] RST_PASS_DURATION   = 32'd60000;
  localparam logic [31:0] RST_REJECT_HOLD     = 32'd20000;
  localparam logic [31:0] RST_SETTLE_MS       = 32'd5000;
  localparam logic [3:0]  RST_MAX_PASSES      = 4'd3;
  localparam logic [15:0] RST_MIN_IMPROVEMENT = 16'd50;

  // Register file contents as seen by the sequencer.
  typedef struct packed {
    logic [11:0] raw_min_level;
    logic [31:0] pass_time_ms;
    logic [31:0] reject_hold_ms;   // floor(pass_time_ms / 3)
    logic [31:0] settle_ms;
    logic [3:0]  max_passes;
    logic [15:0] min_improvement;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        start_request;
    logic        raw_level_valid;
    logic [11:0] raw_level;
    logic        turbidity_valid;
    logic [15:0] turbidity;
    logic [1:0]  verdict;
  } item_t;

  // Sequencer state carried from item to item.
  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] phase_start;
    logic        start_pending;
    logic [15:0] next_batch;
    logic [15:0] cur_batch;
    logic [3:0]  pass_cnt;
    logic [15:0] last_turb;
    logic        last_turb_ok;
    logic [2:0]  reason;
    logic [15:0] delivered;
    logic [15:0] rejected;
    logic [3:0]  drive;
  } state_t;

  // LED flags sampled after the dry check, before the transition.
  typedef struct packed {
    logic led_ok;
    logic led_fault;
  } led_t;

  // Drive word taken on entry to a phase.
  function automatic logic [3:0] drive_on_entry(input logic [2:0] ph,
                                                input logic [3:0] cur);
    logic [3:0] d;
    d = '0;
    case (ph)
      PH_FILTER, PH_RECIRC: begin
        d[DRV_PUMP]   = 1'b1;
        d[DRV_RECIRC] = 1'b1;
      end
      PH_TEST: begin
        d           = cur;
        d[DRV_PUMP] = 1'b0;
      end
      PH_DELIVER: begin
        d[DRV_PUMP]  = 1'b1;
        d[DRV_CLEAN] = 1'b1;
      end
      PH_REJECT: begin
        d[DRV_PUMP]  = 1'b1;
        d[DRV_WASTE] = 1'b1;
      end
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

[rtl/wbts_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbts_cfg
// APB register file; also keeps the reject hold time, one third of the pass
// duration, worked out when the pass duration is written.
// ----------------------------------------------------------------------------
module wbts_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output wbts_pkg::cfg_t     cfg
);
  import wbts_pkg::*;

  // Reciprocal of three: (x * 0xAAAAAAAB) >> 33 equals floor(x / 3) for 32-bit x.
  localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

  cfg_t        cfg_r;
  logic        wr_en;
  logic [2:0]  idx;
  logic [63:0] third_prod;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  assign third_prod = 64'(pwdata) * 64'(RECIP3);

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.raw_min_level   <= RST_RAW_MIN_LEVEL;
      cfg_r.pass_time_ms    <= RST_PASS_DURATION;
      cfg_r.reject_hold_ms  <= RST_REJECT_HOLD;
      cfg_r.settle_ms       <= RST_SETTLE_MS;
      cfg_r.max_passes      <= RST_MAX_PASSES;
      cfg_r.min_improvement <= RST_MIN_IMPROVEMENT;
    end else if (wr_en) begin
      unique case (idx)
        REG_RAW_MIN_LEVEL: cfg_r.raw_min_level <= pwdata[11:0];
        REG_PASS_DURATION: begin
          cfg_r.pass_time_ms   <= pwdata;
          cfg_r.reject_hold_ms <= {1'b0, third_prod[63:33]};
        end
        REG_SETTLE:          cfg_r.settle_ms       <= pwdata;
        REG_MAX_PASSES:      cfg_r.max_passes      <= pwdata[3:0];
        REG_MIN_IMPROVEMENT: cfg_r.min_improvement <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_RAW_MIN_LEVEL:   prdata = {20'd0, cfg_r.raw_min_level};
      REG_PASS_DURATION:   prdata = cfg_r.pass_time_ms;
      REG_SETTLE:          prdata = cfg_r.settle_ms;
      REG_MAX_PASSES:      prdata = {28'd0, cfg_r.max_passes};
      REG_MIN_IMPROVEMENT: prdata = {16'd0, cfg_r.min_improvement};
      default:             prdata = '0;
    endcase
  end

endmodule

[rtl/wbts_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbts_step
// Next-state logic of the sequencer for one sample: start latch, dry check,
// LED sampling and the phase transition.
// ----------------------------------------------------------------------------
module wbts_step (
  input  wbts_pkg::cfg_t   cfg,
  input  wbts_pkg::item_t  item,
  input  wbts_pkg::state_t cur,
  output wbts_pkg::state_t nxt,
  output wbts_pkg::led_t   leds
);
  import wbts_pkg::*;

  logic        level_low;
  logic        dry_hit;
  logic [2:0]  ph1;
  logic [31:0] elapsed;
  logic [13:0] two_level;
  logic [13:0] three_min;
  logic [17:0] turb_plus_min;
  logic        improving;
  logic        go;
  logic [2:0]  target;
  logic [3:0]  drive1;
  logic [31:0] start1;

  assign level_low = item.raw_level_valid && (item.raw_level < cfg.raw_min_level);
  assign dry_hit   = ((cur.phase == PH_FILTER) || (cur.phase == PH_RECIRC)) && level_low;
  assign ph1       = dry_hit ? PH_DRY : cur.phase;
  assign drive1    = dry_hit ? 4'd0 : cur.drive;
  assign start1    = dry_hit ? item.now_ms : cur.phase_start;
  assign elapsed   = item.now_ms - cur.phase_start;

  // Exact 1.5x hysteresis: 2*level >= 3*min.
  assign two_level = {1'b0, item.raw_level, 1'b0};
  assign three_min = {2'b00, cfg.raw_min_level} + {1'b0, cfg.raw_min_level, 1'b0};

  // Improvement: last - turb >= min, rewritten as last >= turb + min.
  assign turb_plus_min = {2'b00, item.turbidity} + {2'b00, cfg.min_improvement};
  always_comb begin
    if (!cur.last_turb_ok)
      improving = 1'b1;
    else if (!item.turbidity_valid)
      improving = 1'b0;
    else
      improving = ({2'b00, cur.last_turb} >= turb_plus_min);
  end

  assign leds.led_fault = (ph1 == PH_DRY) || (ph1 == PH_REJECT);
  assign leds.led_ok    = (ph1 == PH_DELIVER);

  // Transition of the phase in force after the dry check.
  always_comb begin
    nxt = cur;
    nxt.start_pending = cur.start_pending | item.start_request;
    go     = 1'b0;
    target = ph1;
    unique case (ph1)
      PH_IDLE: begin
        if (nxt.start_pending && item.raw_level_valid && !level_low) begin
          nxt.start_pending = 1'b0;
          nxt.cur_batch     = cur.next_batch;
          nxt.next_batch    = cur.next_batch + 16'd1;
          nxt.pass_cnt      = 4'd1;
          nxt.last_turb_ok  = 1'b0;
          nxt.reason        = RSN_NONE;
          go                = 1'b1;
          target            = PH_FILTER;
        end
      end
      PH_FILTER, PH_RECIRC: begin
        if (elapsed >= cfg.pass_time_ms) begin
          go     = 1'b1;
          target = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (elapsed >= cfg.settle_ms) begin
          go     = 1'b1;
          target = PH_TEST;
        end
      end
      PH_TEST: begin
        go = 1'b1;
        if (item.verdict == VERDICT_OK) begin
          target = PH_DELIVER;
        end else if (item.verdict == VERDICT_PH) begin
          target     = PH_REJECT;
          nxt.reason = RSN_PH;
        end else if (item.verdict == VERDICT_SENSOR) begin
          target     = PH_REJECT;
          nxt.reason = RSN_SENSOR;
        end else if (cur.pass_cnt >= cfg.max_passes) begin
          target     = PH_REJECT;
          nxt.reason = RSN_MAX_PASS;
        end else if (!improving) begin
          target     = PH_REJECT;
          nxt.reason = RSN_NO_IMPROV;
        end else begin
          target           = PH_RECIRC;
          nxt.last_turb    = item.turbidity;
          nxt.last_turb_ok = item.turbidity_valid;
          nxt.pass_cnt     = cur.pass_cnt + 4'd1;
        end
      end
      PH_DELIVER: begin
        if (elapsed >= cfg.pass_time_ms) begin
          nxt.delivered = cur.delivered + 16'd1;
          go            = 1'b1;
          target        = PH_IDLE;
        end
      end
      PH_REJECT: begin
        if (elapsed >= cfg.reject_hold_ms) begin
          nxt.rejected = cur.rejected + 16'd1;
          go           = 1'b1;
          target       = PH_IDLE;
        end
      end
      default: begin
        // Dry fault: recover once the level is back at or above 1.5x the minimum.
        if (item.raw_level_valid && (two_level >= three_min)) begin
          go     = 1'b1;
          target = PH_IDLE;
        end
      end
    endcase

    nxt.phase       = go ? target : ph1;
    nxt.phase_start = go ? item.now_ms : start1;
    nxt.drive       = go ? drive_on_entry(target, drive1) : drive1;
  end

endmodule

[rtl/water_batch_treatment_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_batch_treatment_sequencer_core
// Eight-phase batch sequencer for water treatment, one sensor sample in and
// one status item out per step.
//
//   port group | direction | handshake          | carries
//   in_*       | in        | tvalid / tready    | one timed sensor sample
//   out_*      | out       | tvalid / tready    | phase, drives, LEDs, counters
//   cfg_*      | in        | APB psel / penable | five setup registers
//
// An item enters the input register, and the step logic then updates the
// sequencer state and loads the result register. It sustains one item per
// cycle while the output does not stall. The input side keeps taking items
// while a result waits, as long as the result register can move on. A stall
// on the output holds both registers. Reset (synchronous, active low) sets
// the idle phase, clears all counters and loads the register defaults.
// ----------------------------------------------------------------------------
module water_batch_treatment_sequencer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // now_ms[31:0], start_request[32], raw_level_valid[33], raw_level[45:34],
  // turbidity_valid[46], turbidity[62:47], verdict[64:63], zero pad[71:65]
  input  logic [wbts_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // phase[2:0], pump_on[3], valve_clean[4], valve_recirc[5], valve_waste[6],
  // led_ok[7], led_fault[8], batch_number[24:9], pass_count[28:25],
  // reject_reason[31:29], delivered_count[47:32], rejected_count[63:48]
  output logic [wbts_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [4:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import wbts_pkg::*;

  cfg_t   cfg;
  item_t  in_item_r;
  logic   in_valid_r;
  logic   out_valid_r;
  state_t state_r;
  state_t state_nxt;
  led_t   leds;
  led_t   leds_r;
  logic   advance;
  logic   in_accept;

  wbts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  wbts_step u_step (
    .cfg  (cfg),
    .item (in_item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .leds (leds)
  );

  // Handshake: the step runs when an item is held and the result slot frees.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  // Input item register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r.now_ms          <= in_tdata[31:0];
      in_item_r.start_request   <= in_tdata[32];
      in_item_r.raw_level_valid <= in_tdata[33];
      in_item_r.raw_level       <= in_tdata[45:34];
      in_item_r.turbidity_valid <= in_tdata[46];
      in_item_r.turbidity       <= in_tdata[62:47];
      in_item_r.verdict         <= in_tdata[64:63];
    end
  end

  // Control, sequencer state and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      leds_r                <= '0;
      state_r.phase         <= PH_IDLE;
      state_r.phase_start   <= '0;
      state_r.start_pending <= 1'b0;
      state_r.next_batch    <= '0;
      state_r.cur_batch     <= '0;
      state_r.pass_cnt      <= '0;
      state_r.last_turb     <= '0;
      state_r.last_turb_ok  <= 1'b0;
      state_r.reason        <= RSN_NONE;
      state_r.delivered     <= '0;
      state_r.rejected      <= '0;
      state_r.drive         <= '0;
    end else begin
      if (in_accept)
        in_valid_r <= 1'b1;
      else if (advance)
        in_valid_r <= 1'b0;

      if (advance)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;

      if (advance) begin
        state_r <= state_nxt;
        leds_r  <= leds;
      end
    end
  end

  // The result is the state after the step plus the sampled LEDs.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {state_r.rejected,
                       state_r.delivered,
                       state_r.reason,
                       state_r.pass_cnt,
                       state_r.cur_batch,
                       leds_r.led_fault,
                       leds_r.led_ok,
                       state_r.drive[DRV_WASTE],
                       state_r.drive[DRV_RECIRC],
                       state_r.drive[DRV_CLEAN],
                       state_r.drive[DRV_PUMP],
                       state_r.phase};

endmodule

[rtl/wbts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbts_checker
// Port-level checks on the result channel of the sequencer, bound to the
// top level.
// ----------------------------------------------------------------------------
module wbts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic [wbts_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready
);
  import wbts_pkg::*;

  logic [2:0] phase;
  logic       pump_on;
  logic       valve_clean;
  logic       valve_waste;
  logic       led_ok;
  logic       led_fault;
  logic [2:0] reason;

  assign phase       = out_tdata[2:0];
  assign pump_on     = out_tdata[3];
  assign valve_clean = out_tdata[4];
  assign valve_waste = out_tdata[6];
  assign led_ok      = out_tdata[7];
  assign led_fault   = out_tdata[8];
  assign reason      = out_tdata[31:29];

  // No result is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // The OK LED means the sample met the deliver phase, which only ends in idle.
  a_led_ok_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && led_ok |-> !led_fault && (phase == PH_DELIVER || phase == PH_IDLE))
    else $error("OK LED outside delivery");

  // A rejected batch always names its reason and drains through the waste valve.
  a_reject_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && phase == PH_REJECT |->
      reason != RSN_NONE && pump_on && valve_waste && !valve_clean)
    else $error("reject phase with wrong reason or drives");

endmodule

bind water_batch_treatment_sequencer_core wbts_checker u_wbts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the water batch treatment sequencer. Sensor
// items go in on the input stream and the testbench keeps its own copy of
// the sequencer: phase, timers, batch data and drives. Each accepted item
// queues the status that the block should report, and every status item that
// leaves the block is compared field by field with the oldest one queued.
// A directed part walks the start, dry fault and verdict paths. Random
// segments then run under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;
  import wbts_pkg::*;

  // Input item, declared from the top bit down so that it maps onto in_tdata.
  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] turbidity;
    logic        turbidity_valid;
    logic [11:0] raw_level;
    logic        raw_level_valid;
    logic        start_request;
    logic [31:0] now_ms;
  } sample_t;

  // Status item, declared from the top bit down so that it maps onto out_tdata.
  typedef struct packed {
    logic [15:0] rejected_count;
    logic [15:0] delivered_count;
    logic [2:0]  reject_reason;
    logic [3:0]  pass_count;
    logic [15:0] batch_number;
    logic        led_fault;
    logic        led_ok;
    logic        valve_waste;
    logic        valve_recirc;
    logic        valve_clean;
    logic        pump_on;
    logic [2:0]  phase;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [4:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Idling percentages for the sender and the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  // Sensor time cursor used to build items.
  logic [31:0] clock_ms = 32'd1000;

  // Mirror of the setup registers.
  logic [11:0] lim_min_level  = RST_RAW_MIN_LEVEL;
  logic [31:0] lim_pass_ms    = RST_PASS_DURATION;
  logic [31:0] lim_settle_ms  = RST_SETTLE_MS;
  logic [3:0]  lim_max_passes = RST_MAX_PASSES;
  logic [15:0] lim_min_improv = RST_MIN_IMPROVEMENT;

  // Sequencer state as predicted, starting from its reset values.
  logic [2:0]  seq_phase = PH_IDLE;
  logic [31:0] seq_phase_start = '0;
  logic        seq_start_pending = 1'b0;
  logic [15:0] seq_next_batch = '0;
  logic [15:0] seq_cur_batch = '0;
  logic [3:0]  seq_passes = '0;
  logic [15:0] seq_last_turb = '0;
  logic        seq_last_turb_ok = 1'b0;
  logic [2:0]  seq_reason = RSN_NONE;
  logic [15:0] seq_delivered = '0;
  logic [15:0] seq_rejected = '0;
  logic [3:0]  seq_drive = '0;

  status_t expected_status[$];
  status_t want_status;
  status_t got_status;

  water_batch_treatment_sequencer_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Move into a phase and set the drives that go with it.
  task automatic enter_phase(input logic [2:0] ph, input logic [31:0] now);
    seq_phase       = ph;
    seq_phase_start = now;
    case (ph)
      PH_FILTER, PH_RECIRC: seq_drive = (4'b1 << DRV_PUMP) | (4'b1 << DRV_RECIRC);
      PH_TEST:              seq_drive[DRV_PUMP] = 1'b0;
      PH_DELIVER:           seq_drive = (4'b1 << DRV_PUMP) | (4'b1 << DRV_CLEAN);
      PH_REJECT:            seq_drive = (4'b1 << DRV_PUMP) | (4'b1 << DRV_WASTE);
      default:              seq_drive = '0;
    endcase
  endtask

  // Advance the predicted sequencer by one item and queue the status it gives.
  task automatic advance_sequencer(input sample_t s);
    logic [31:0] elapsed;
    logic        led_ok;
    logic        led_fault;
    logic        improving;
    status_t     st;
    elapsed = s.now_ms - seq_phase_start;
    if (s.start_request) seq_start_pending = 1'b1;

    // A valid low level while water moves is a dry run.
    if ((seq_phase == PH_FILTER || seq_phase == PH_RECIRC) && s.raw_level_valid &&
        s.raw_level < lim_min_level)
      enter_phase(PH_DRY, s.now_ms);
    led_fault = (seq_phase == PH_DRY || seq_phase == PH_REJECT);
    led_ok    = (seq_phase == PH_DELIVER);

    case (seq_phase)
      PH_IDLE: begin
        if (seq_start_pending && s.raw_level_valid && s.raw_level >= lim_min_level) begin
          seq_start_pending = 1'b0;
          seq_cur_batch     = seq_next_batch;
          seq_next_batch    = seq_next_batch + 16'd1;
          seq_passes        = 4'd1;
          seq_last_turb_ok  = 1'b0;
          seq_reason        = RSN_NONE;
          enter_phase(PH_FILTER, s.now_ms);
        end
      end
      PH_FILTER, PH_RECIRC: begin
        if (elapsed >= lim_pass_ms) enter_phase(PH_SETTLE, s.now_ms);
      end
      PH_SETTLE: begin
        if (elapsed >= lim_settle_ms) enter_phase(PH_TEST, s.now_ms);
      end
      PH_TEST: begin
        if (s.verdict == VERDICT_OK) begin
          enter_phase(PH_DELIVER, s.now_ms);
        end else if (s.verdict == VERDICT_PH) begin
          seq_reason = RSN_PH;
          enter_phase(PH_REJECT, s.now_ms);
        end else if (s.verdict == VERDICT_SENSOR) begin
          seq_reason = RSN_SENSOR;
          enter_phase(PH_REJECT, s.now_ms);
        end else if (seq_passes >= lim_max_passes) begin
          seq_reason = RSN_MAX_PASS;
          enter_phase(PH_REJECT, s.now_ms);
        end else begin
          // The drop since the last pass is a signed difference.
          if (!seq_last_turb_ok) improving = 1'b1;
          else if (!s.turbidity_valid) improving = 1'b0;
          else improving = (int'(seq_last_turb) - int'(s.turbidity)) >= int'(lim_min_improv);
          if (!improving) begin
            seq_reason = RSN_NO_IMPROV;
            enter_phase(PH_REJECT, s.now_ms);
          end else begin
            seq_last_turb    = s.turbidity;
            seq_last_turb_ok = s.turbidity_valid;
            seq_passes       = seq_passes + 4'd1;
            enter_phase(PH_RECIRC, s.now_ms);
          end
        end
      end
      PH_DELIVER: begin
        if (elapsed >= lim_pass_ms) begin
          seq_delivered = seq_delivered + 16'd1;
          enter_phase(PH_IDLE, s.now_ms);
        end
      end
      PH_REJECT: begin
        if (elapsed >= lim_pass_ms / 3) begin
          seq_rejected = seq_rejected + 16'd1;
          enter_phase(PH_IDLE, s.now_ms);
        end
      end
      default: begin
        // Recovery from a dry run needs 1.5 times the minimum level.
        if (s.raw_level_valid && 2 * int'(s.raw_level) >= 3 * int'(lim_min_level))
          enter_phase(PH_IDLE, s.now_ms);
      end
    endcase

    st.phase           = seq_phase;
    st.pump_on         = seq_drive[DRV_PUMP];
    st.valve_clean     = seq_drive[DRV_CLEAN];
    st.valve_recirc    = seq_drive[DRV_RECIRC];
    st.valve_waste     = seq_drive[DRV_WASTE];
    st.led_ok          = led_ok;
    st.led_fault       = led_fault;
    st.batch_number    = seq_cur_batch;
    st.pass_count      = seq_passes;
    st.reject_reason   = seq_reason;
    st.delivered_count = seq_delivered;
    st.rejected_count  = seq_rejected;
    expected_status.push_back(st);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each status item that leaves the block with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        $error("status item with no item pending: %h", out_tdata);
        mismatch_count++;
      end else begin
        want_status = expected_status.pop_front();
        got_status  = status_t'(out_tdata);
        check_field("phase", 32'(want_status.phase), 32'(got_status.phase));
        check_field("pump_on", 32'(want_status.pump_on), 32'(got_status.pump_on));
        check_field("valve_clean", 32'(want_status.valve_clean),
                    32'(got_status.valve_clean));
        check_field("valve_recirc", 32'(want_status.valve_recirc),
                    32'(got_status.valve_recirc));
        check_field("valve_waste", 32'(want_status.valve_waste),
                    32'(got_status.valve_waste));
        check_field("led_ok", 32'(want_status.led_ok), 32'(got_status.led_ok));
        check_field("led_fault", 32'(want_status.led_fault), 32'(got_status.led_fault));
        check_field("batch_number", 32'(want_status.batch_number),
                    32'(got_status.batch_number));
        check_field("pass_count", 32'(want_status.pass_count),
                    32'(got_status.pass_count));
        check_field("reject_reason", 32'(want_status.reject_reason),
                    32'(got_status.reject_reason));
        check_field("delivered_count", 32'(want_status.delivered_count),
                    32'(got_status.delivered_count));
        check_field("rejected_count", 32'(want_status.rejected_count),
                    32'(got_status.rejected_count));
      end
    end
  end

  // Send one item, idling first at the current rate, and predict it once taken.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= IN_DATA_W'(s);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    advance_sequencer(s);
  endtask

  // Advance the time cursor and send an item built from the given fields.
  task automatic send_at(input logic [31:0] advance, input logic start,
                         input logic lvl_ok, input logic [11:0] lvl,
                         input logic turb_ok, input logic [15:0] turb,
                         input logic [1:0] verdict);
    sample_t s;
    clock_ms          = clock_ms + advance;
    s.now_ms          = clock_ms;
    s.start_request   = start;
    s.raw_level_valid = lvl_ok;
    s.raw_level       = lvl;
    s.turbidity_valid = turb_ok;
    s.turbidity       = turb;
    s.verdict         = verdict;
    send_sample(s);
  endtask

  // Stop sending and wait until every expected status item has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (index)
      REG_RAW_MIN_LEVEL:   lim_min_level  = value[11:0];
      REG_PASS_DURATION:   lim_pass_ms    = value;
      REG_SETTLE:          lim_settle_ms  = value;
      REG_MAX_PASSES:      lim_max_passes = value[3:0];
      REG_MIN_IMPROVEMENT: lim_min_improv = value[15:0];
      default: ;
    endcase
  endtask

  // Let the block go idle, then write all five registers.
  task automatic set_config(input logic [11:0] min_level, input logic [31:0] pass_ms,
                            input logic [31:0] settle_ms, input logic [3:0] max_passes,
                            input logic [15:0] min_improv);
    drain_results();
    write_reg(REG_RAW_MIN_LEVEL, 32'(min_level));
    write_reg(REG_PASS_DURATION, pass_ms);
    write_reg(REG_SETTLE, settle_ms);
    write_reg(REG_MAX_PASSES, 32'(max_passes));
    write_reg(REG_MIN_IMPROVEMENT, 32'(min_improv));
  endtask

  // Start a batch and step through filter and settle into the test phase.
  task automatic start_batch_to_test();
    send_at(0, 1'b1, 1'b1, 12'd100, 1'b1, 16'd500, VERDICT_OK);
    send_at(1, 1'b0, 1'b1, 12'd100, 1'b1, 16'd500, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd500, VERDICT_OK);
  endtask

  // Start request latching, level gating of the start, and the dry fault.
  task automatic test_start_and_dry_fault();
    // The request waits while the level is unknown or too low.
    send_at(0, 1'b1, 1'b0, 12'd0, 1'b1, 16'd0, VERDICT_OK);
    send_at(10, 1'b0, 1'b1, 12'd99, 1'b1, 16'd0, VERDICT_OK);
    send_at(10, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    // One millisecond before the filter time runs out.
    send_at(59999, 1'b0, 1'b1, 12'hFFF, 1'b1, 16'd0, VERDICT_OK);
    // A low level wins over the end of the filter time.
    send_at(1, 1'b0, 1'b1, 12'd99, 1'b1, 16'd0, VERDICT_OK);
    // Just under and just at the recovery level.
    send_at(5, 1'b0, 1'b1, 12'd149, 1'b1, 16'd0, VERDICT_OK);
    send_at(5, 1'b0, 1'b1, 12'd150, 1'b1, 16'd0, VERDICT_OK);
  endtask

  // Short phases across the time wrap: every verdict and rejection reason.
  task automatic test_short_phase_batches();
    set_config(12'd100, 32'd1, 32'd0, 4'd3, 16'd0);
    clock_ms = 32'hFFFF_FFFF;

    // Three passes end in the pass limit; an unknown level never faults.
    send_at(0, 1'b1, 1'b1, 12'hFFF, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(1, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'hFFFF, VERDICT_TURBID);
    send_at(1, 1'b0, 1'b0, 12'd0, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'hFFFF, VERDICT_TURBID);
    send_at(1, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_TURBID);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);

    // pH out of range.
    start_batch_to_test();
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_PH);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);

    // Unreliable sensor.
    start_batch_to_test();
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_SENSOR);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);

    // An unknown turbidity after a known one is no improvement.
    start_batch_to_test();
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd200, VERDICT_TURBID);
    send_at(1, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b0, 16'd0, VERDICT_TURBID);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);

    // Delivery, held for one step and then back to idle.
    start_batch_to_test();
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(0, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
    send_at(1, 1'b0, 1'b1, 12'd100, 1'b1, 16'd0, VERDICT_OK);
  endtask

  // Build one random item. Most follow the batch: times that land on or just
  // short of the phase end, levels near the thresholds and turbidity near the
  // required drop. A few are plain noise.
  task automatic random_step();
    sample_t     s;
    logic [95:0] noise;
    logic [31:0] dur;
    logic [31:0] remaining;
    logic        timed;
    int          pick;
    int          target;
    int          hyst;
    timed = 1'b1;
    dur   = '0;
    case (seq_phase)
      PH_FILTER, PH_RECIRC, PH_DELIVER: dur = lim_pass_ms;
      PH_SETTLE:                        dur = lim_settle_ms;
      PH_REJECT:                        dur = lim_pass_ms / 3;
      default:                          timed = 1'b0;
    endcase

    if ($urandom_range(99) < 8) begin
      noise = {$urandom(), $urandom(), $urandom()};
      s = sample_t'(noise[$bits(sample_t)-1:0]);
      clock_ms = s.now_ms;
    end else begin
      remaining = dur - (clock_ms - seq_phase_start);
      pick = $urandom_range(99);
      if (timed && pick < 40) clock_ms = clock_ms + remaining;
      else if (timed && pick < 55) clock_ms = clock_ms + remaining - 1;
      else if (pick < 80) clock_ms = clock_ms + $urandom_range(1000);
      else if (pick < 90) clock_ms = $urandom();
      s.now_ms = clock_ms;
      s.start_request = ($urandom_range(99) < ((seq_phase == PH_IDLE) ? 60 : 15));

      s.raw_level_valid = ($urandom_range(99) < 88);
      hyst = (3 * int'(lim_min_level) + 1) / 2 - int'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 10 && lim_min_level != 0)
        s.raw_level = 12'($urandom_range(int'(lim_min_level) - 1));
      else if (pick < 25 && seq_phase == PH_DRY)
        s.raw_level = (hyst > 4095) ? 12'hFFF : ((hyst < 0) ? 12'd0 : 12'(hyst));
      else if (pick < 40)
        s.raw_level = 12'($urandom_range(4095));
      else
        s.raw_level = 12'($urandom_range(4095, int'(lim_min_level)));

      s.turbidity_valid = ($urandom_range(99) < 90);
      target = int'(seq_last_turb) - int'(lim_min_improv) + int'($urandom_range(2)) - 1;
      if (seq_last_turb_ok && $urandom_range(1) == 1 && target >= 0 && target <= 65535)
        s.turbidity = 16'(target);
      else
        s.turbidity = 16'($urandom());

      pick = $urandom_range(99);
      if (pick < 20) s.verdict = VERDICT_OK;
      else if (pick < 30) s.verdict = VERDICT_PH;
      else if (pick < 40) s.verdict = VERDICT_SENSOR;
      else s.verdict = VERDICT_TURBID;
    end
    send_sample(s);
  endtask

  // Random segments, each under its own register setting and idling pattern.
  task automatic test_random_segments();
    int seg;
    for (seg = 0; seg < 8; seg++) begin
      case (seg)
        0: set_config(RST_RAW_MIN_LEVEL, RST_PASS_DURATION, RST_SETTLE_MS,
                      RST_MAX_PASSES, RST_MIN_IMPROVEMENT);
        1: set_config(12'd0, 32'd1, 32'd0, 4'd1, 16'd0);
        2: set_config(12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);
        default: set_config(($urandom_range(1) == 1) ? 12'($urandom_range(400))
                                                     : 12'($urandom_range(4095)),
                            ($urandom_range(1) == 1) ? 32'($urandom_range(200, 1))
                                                     : ($urandom() | 32'd1),
                            ($urandom_range(1) == 1) ? 32'($urandom_range(50))
                                                     : $urandom(),
                            4'($urandom_range(15, 1)),
                            ($urandom_range(1) == 1) ? 16'($urandom_range(100))
                                                     : 16'($urandom()));
      endcase
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      repeat (62) random_step();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_start_and_dry_fault();
    test_short_phase_batches();
    test_random_segments();
    drain_results();
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
rtl/wbts_pkg.sv
rtl/wbts_cfg.sv
rtl/wbts_step.sv
rtl/water_batch_treatment_sequencer_core.sv
rtl/wbts_checker.sv
test/tb.sv
